// File: rtl/chf_pkg.sv
package chf_pkg;

	localparam int CORDIC_STEPS_DEF    = 16;
	localparam int ANGLE_FRAC_BITS_DEF = 7;

	localparam int MAG_W      = 16;
	localparam int COEF_W     = 16;
	localparam int OFF_W      = 20;
	localparam int CAL_W      = 17;
	localparam int HEAD_W     = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 20;
	localparam int ZFRAC      = 20;
	localparam int ANGLE_W    = 30;
	localparam int VEC_W      = 28;
	localparam int MUL_W      = 18;
	localparam int ACC_W      = 33;

	typedef logic [CFG_IDX_W-1:0] reg_idx_t;

	localparam reg_idx_t REG_COEF_XX  = 3'd0;
	localparam reg_idx_t REG_COEF_XY  = 3'd1;
	localparam reg_idx_t REG_COEF_XZ  = 3'd2;
	localparam reg_idx_t REG_COEF_YX  = 3'd3;
	localparam reg_idx_t REG_COEF_YY  = 3'd4;
	localparam reg_idx_t REG_COEF_YZ  = 3'd5;
	localparam reg_idx_t REG_OFFSET_X = 3'd6;
	localparam reg_idx_t REG_OFFSET_Y = 3'd7;

	localparam logic signed [COEF_W-1:0] COEF_XX_RST = 16'sd23;
	localparam logic signed [COEF_W-1:0] COEF_XY_RST = 16'sd15924;
	localparam logic signed [COEF_W-1:0] COEF_XZ_RST = 16'sd48;
	localparam logic signed [COEF_W-1:0] COEF_YX_RST = 16'sd16318;
	localparam logic signed [COEF_W-1:0] COEF_YY_RST = 16'sd23;
	localparam logic signed [COEF_W-1:0] COEF_YZ_RST = -16'sd203;
	localparam logic signed [OFF_W-1:0]  OFFSET_X_RST = 20'sd2;
	localparam logic signed [OFF_W-1:0]  OFFSET_Y_RST = 20'sd757;

	// 180 degrees in 2^-20 degree units
	localparam logic signed [ANGLE_W-1:0] DEG180_Q20 = 30'sd188743680;

	// ceil(2^17 / 3), exact floor division by 3 for values below 2^17
	localparam logic signed [MUL_W-1:0] DIV3_RECIP = 18'sd43691;
	localparam int DIV3_SH = 17;

	function automatic logic signed [ANGLE_W-1:0] atan_q20(input logic [4:0] idx);
		logic signed [ANGLE_W-1:0] v;
		unique case (idx)
			5'd0:  v = 30'sd47185920;
			5'd1:  v = 30'sd27855475;
			5'd2:  v = 30'sd14718068;
			5'd3:  v = 30'sd7471121;
			5'd4:  v = 30'sd3750058;
			5'd5:  v = 30'sd1876857;
			5'd6:  v = 30'sd938658;
			5'd7:  v = 30'sd469357;
			5'd8:  v = 30'sd234682;
			5'd9:  v = 30'sd117342;
			5'd10: v = 30'sd58671;
			5'd11: v = 30'sd29335;
			5'd12: v = 30'sd14668;
			5'd13: v = 30'sd7334;
			5'd14: v = 30'sd3667;
			5'd15: v = 30'sd1833;
			5'd16: v = 30'sd917;
			5'd17: v = 30'sd458;
			5'd18: v = 30'sd229;
			5'd19: v = 30'sd115;
			5'd20: v = 30'sd57;
			5'd21: v = 30'sd29;
			5'd22: v = 30'sd14;
			5'd23: v = 30'sd7;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

// File: rtl/compass_heading_filter_top.sv
// Each item runs through calibration, setup, CORDIC_STEPS vector steps, rounding,
// averaging and the divide by 3, then is loaded into the output register once that is
// free; with cal_x zero the vector steps, rounding, averaging and divide are skipped. One
// item at a time; the next is taken once the result is loaded into the output register.
// All work runs on one 18x18 multiplier and one CORDIC add/shift stage.
// Reset restores register defaults and clears history.
module compass_heading_filter_top #(
	parameter int CORDIC_STEPS    = chf_pkg::CORDIC_STEPS_DEF,
	parameter int ANGLE_FRAC_BITS = chf_pkg::ANGLE_FRAC_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [47:0] s_axis_tdata,  // mag_x, mag_y, mag_z
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [55:0] m_axis_tdata,  // heading_deg, cal_x, cal_y, zero pad
	output logic        m_axis_tuser,  // held
	input  logic        cfg_we,
	input  logic [chf_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [chf_pkg::CFG_DATA_W-1:0] cfg_data
);

	localparam int CNT_W = (CORDIC_STEPS > 8) ? $clog2(CORDIC_STEPS) : 3;
	localparam int RND_SH = chf_pkg::ZFRAC - ANGLE_FRAC_BITS;
	localparam logic signed [chf_pkg::ANGLE_W-1:0] RND_HALF = 30'sd1 <<< (RND_SH - 1);
	localparam logic signed [chf_pkg::ANGLE_W-1:0] HEAD_LIM = 30'sd180 <<< ANGLE_FRAC_BITS;
	localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(CORDIC_STEPS - 1);
	localparam logic [CNT_W-1:0] CAL_X_STEP = CNT_W'(4);
	localparam logic [CNT_W-1:0] CAL_LAST = CNT_W'(7);

	typedef enum logic [7:0] {
		ST_IDLE = 8'b00000001,
		ST_CAL  = 8'b00000010,
		ST_INIT = 8'b00000100,
		ST_CORD = 8'b00001000,
		ST_RND  = 8'b00010000,
		ST_SUM  = 8'b00100000,
		ST_DIV  = 8'b01000000,
		ST_DONE = 8'b10000000
	} state_t;

	state_t state_q;
	logic [CNT_W-1:0] step_q;

	logic signed [chf_pkg::COEF_W-1:0] coef_q [6];
	logic signed [chf_pkg::OFF_W-1:0]  off_x_q, off_y_q;
	logic signed [chf_pkg::HEAD_W-1:0] last_q, older_q;

	logic signed [chf_pkg::MAG_W-1:0] mag_q [3];
	logic signed [2*chf_pkg::MUL_W-1:0] prod_q;
	logic signed [chf_pkg::ACC_W-1:0] acc_q;
	logic signed [chf_pkg::CAL_W-1:0] cal_x_q, cal_y_q;
	logic signed [chf_pkg::VEC_W-1:0] x_q, y_q;
	logic signed [chf_pkg::ANGLE_W-1:0] z_q;
	logic signed [chf_pkg::HEAD_W-1:0] r_q;
	logic signed [17:0] sum_q;
	logic held_q;

	logic m_valid_q;
	logic signed [chf_pkg::HEAD_W-1:0] out_head_q;
	logic signed [chf_pkg::CAL_W-1:0] out_cal_x_q, out_cal_y_q;
	logic out_held_q;

	logic s_fire, out_free;
	logic [2:0] k, k_acc;
	logic signed [chf_pkg::MUL_W-1:0] mul_a, mul_b;
	logic signed [2*chf_pkg::MUL_W-1:0] mul_p;
	logic signed [chf_pkg::ACC_W-1:0] prod_acc, off_x_sh, off_y_sh;
	logic signed [chf_pkg::MAG_W-1:0] mag_sel;
	logic signed [chf_pkg::COEF_W-1:0] coef_sel;
	logic signed [17:0] sum_abs;
	logic signed [chf_pkg::VEC_W-1:0] dx, dy, x0, cy256;
	logic signed [chf_pkg::ANGLE_W-1:0] atan_v, rnd_t, rnd_s;
	logic signed [chf_pkg::HEAD_W-1:0] rnd_c;
	logic [16:0] quot;
	logic [16:0] head_div;
	logic signed [chf_pkg::HEAD_W-1:0] head_new;

	function automatic logic signed [chf_pkg::CAL_W-1:0] cal_conv(
		input logic signed [chf_pkg::ACC_W-1:0] acc);
		logic signed [chf_pkg::ACC_W-1:0] t;
		logic signed [18:0] q;
		t = acc + (acc[chf_pkg::ACC_W-1] ? 33'sd16383 : 33'sd0);
		q = t[32:14];
		if (q > 19'sd65535) begin
			return 17'sd65535;
		end else if (q < -19'sd65536) begin
			return -17'sd65536;
		end
		return q[16:0];
	endfunction

	assign s_axis_tready = (state_q == ST_IDLE);
	assign s_fire = s_axis_tvalid && s_axis_tready;
	assign out_free = !m_valid_q || m_axis_tready;

	assign k = step_q[2:0];
	assign k_acc = k - 3'd1;

	always_comb begin
		unique case (k)
			3'd0, 3'd3: mag_sel = mag_q[0];
			3'd1, 3'd4: mag_sel = mag_q[1];
			default:    mag_sel = mag_q[2];
		endcase
		coef_sel = (k < 3'd6) ? coef_q[k] : '0;
	end

	assign sum_abs = sum_q[17] ? -sum_q : sum_q;

	// shared multiplier: soft-iron products, then reciprocal divide by 3
	always_comb begin
		if (state_q == ST_CAL) begin
			mul_a = {{2{coef_sel[15]}}, coef_sel};
			mul_b = {{2{mag_sel[15]}}, mag_sel};
		end else begin
			mul_a = sum_abs;
			mul_b = chf_pkg::DIV3_RECIP;
		end
	end
	assign mul_p = mul_a * mul_b;

	assign prod_acc = prod_q[chf_pkg::ACC_W-1:0];
	assign off_x_sh = {{3{off_x_q[19]}}, off_x_q, 10'b0};
	assign off_y_sh = {{3{off_y_q[19]}}, off_y_q, 10'b0};

	assign dx = y_q >>> step_q;
	assign dy = x_q >>> step_q;
	assign atan_v = chf_pkg::atan_q20(5'(step_q));
	assign x0 = {{3{cal_x_q[16]}}, cal_x_q, 8'b0};
	assign cy256 = {{3{cal_y_q[16]}}, cal_y_q, 8'b0};

	always_comb begin
		rnd_t = z_q + RND_HALF;
		rnd_s = rnd_t >>> RND_SH;
		if (rnd_s > HEAD_LIM) begin
			rnd_c = HEAD_LIM[15:0];
		end else if (rnd_s < -HEAD_LIM) begin
			rnd_c = 16'(-HEAD_LIM);
		end else begin
			rnd_c = rnd_s[15:0];
		end
	end

	assign quot = prod_q[chf_pkg::DIV3_SH+16:chf_pkg::DIV3_SH];
	assign head_div = sum_q[17] ? (17'd0 - quot) : quot;
	assign head_new = held_q ? last_q : head_div[15:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q <= '0;
			m_valid_q <= 1'b0;
			last_q <= '0;
			older_q <= '0;
			coef_q[0] <= chf_pkg::COEF_XX_RST;
			coef_q[1] <= chf_pkg::COEF_XY_RST;
			coef_q[2] <= chf_pkg::COEF_XZ_RST;
			coef_q[3] <= chf_pkg::COEF_YX_RST;
			coef_q[4] <= chf_pkg::COEF_YY_RST;
			coef_q[5] <= chf_pkg::COEF_YZ_RST;
			off_x_q <= chf_pkg::OFFSET_X_RST;
			off_y_q <= chf_pkg::OFFSET_Y_RST;
		end else begin
			if (cfg_we) begin
				if (cfg_idx == chf_pkg::REG_OFFSET_X) begin
					off_x_q <= cfg_data;
				end else if (cfg_idx == chf_pkg::REG_OFFSET_Y) begin
					off_y_q <= cfg_data;
				end else begin
					coef_q[cfg_idx] <= cfg_data[15:0];
				end
			end
			if (m_valid_q && m_axis_tready && state_q != ST_DONE) begin
				m_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_fire) begin
						state_q <= ST_CAL;
						step_q <= '0;
					end
				end
				ST_CAL: begin
					if (step_q == CAL_LAST) begin
						state_q <= ST_INIT;
						step_q <= '0;
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				ST_INIT: begin
					state_q <= (cal_x_q == '0) ? ST_DONE : ST_CORD;
					step_q <= '0;
				end
				ST_CORD: begin
					if (step_q == LAST_STEP) begin
						state_q <= ST_RND;
						step_q <= '0;
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				ST_RND: state_q <= ST_SUM;
				ST_SUM: state_q <= ST_DIV;
				ST_DIV: state_q <= ST_DONE;
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
						m_valid_q <= 1'b1;
						if (!held_q) begin
							older_q <= last_q;
							last_q <= head_new;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (s_fire) begin
			mag_q[0] <= s_axis_tdata[15:0];
			mag_q[1] <= s_axis_tdata[31:16];
			mag_q[2] <= s_axis_tdata[47:32];
		end
		prod_q <= mul_p;
		unique case (state_q)
			ST_CAL: begin
				if (step_q != '0 && step_q != CAL_LAST) begin
					if (k_acc == 3'd0) begin
						acc_q <= prod_acc - off_x_sh;
					end else if (k_acc == 3'd3) begin
						acc_q <= prod_acc - off_y_sh;
					end else begin
						acc_q <= acc_q + prod_acc;
					end
				end
				if (step_q == CAL_X_STEP) begin
					cal_x_q <= cal_conv(acc_q);
				end
				if (step_q == CAL_LAST) begin
					cal_y_q <= cal_conv(acc_q);
				end
			end
			ST_INIT: begin
				held_q <= (cal_x_q == '0);
				if (cal_x_q[16]) begin
					// left half plane: turn by 180 degrees first
					x_q <= -x0;
					y_q <= cy256;
					z_q <= (cal_y_q[16] || cal_y_q == '0) ? chf_pkg::DEG180_Q20
						: -chf_pkg::DEG180_Q20;
				end else begin
					x_q <= x0;
					y_q <= -cy256;
					z_q <= '0;
				end
			end
			ST_CORD: begin
				if (y_q > 0) begin
					x_q <= x_q + dx;
					y_q <= y_q - dy;
					z_q <= z_q + atan_v;
				end else begin
					x_q <= x_q - dx;
					y_q <= y_q + dy;
					z_q <= z_q - atan_v;
				end
			end
			ST_RND: r_q <= rnd_c;
			ST_SUM: begin
				sum_q <= {{2{r_q[15]}}, r_q} + {{2{last_q[15]}}, last_q}
					+ {{2{older_q[15]}}, older_q};
			end
			ST_DONE: begin
				if (out_free) begin
					out_head_q <= head_new;
					out_cal_x_q <= cal_x_q;
					out_cal_y_q <= cal_y_q;
					out_held_q <= held_q;
				end
			end
			default: ;
		endcase
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata = {6'b0, out_cal_y_q, out_cal_x_q, out_head_q};
	assign m_axis_tuser = out_held_q;

	a_out_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> out_head_q == last_q)
		else $error("output heading differs from history head");

	a_held_zero_x: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> out_cal_x_q == '0)
		else $error("held item with nonzero cal_x");

	a_cord_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CORD |-> cal_x_q != '0)
		else $error("CORDIC running on zero cal_x");

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		s_fire |=> state_q == ST_CAL && step_q == '0)
		else $error("accepted item did not start calibration");

	a_head_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> out_head_q <= HEAD_LIM && out_head_q >= -HEAD_LIM)
		else $error("heading out of range");

endmodule

// File: test/testbench.sv
`timescale 1ns / 100ps

module testbench;

	import chf_pkg::*;

	localparam int STEPS      = CORDIC_STEPS_DEF;
	localparam int FRAC       = ANGLE_FRAC_BITS_DEF;
	localparam int STALL_LIMIT = 3000;

	typedef struct packed {
		logic signed [HEAD_W-1:0] heading;
		logic signed [CAL_W-1:0]  cal_x;
		logic signed [CAL_W-1:0]  cal_y;
		logic                     held;
	} heading_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [47:0] s_axis_tdata = '0;   // mag_x, mag_y, mag_z
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [55:0] m_axis_tdata;        // heading_deg, cal_x, cal_y, zero pad
	logic        m_axis_tuser;        // held
	logic        cfg_we = 1'b0;
	reg_idx_t    cfg_idx = REG_COEF_XX;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	compass_heading_filter_top u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_we        (cfg_we),
		.cfg_idx       (cfg_idx),
		.cfg_data      (cfg_data)
	);

	initial forever #5 clk = ~clk;

	// heading model state
	logic signed [COEF_W-1:0] coef_reg [6];
	logic signed [OFF_W-1:0]  off_x_reg;
	logic signed [OFF_W-1:0]  off_y_reg;
	int hist_last;
	int hist_older;
	int hist_oldest;

	// atan(2^-i) in 2^-20 degree
	longint atan_tab [24] = '{
		47185920, 27855475, 14718068, 7471121, 3750058, 1876857, 938658, 469357,
		234682, 117342, 58671, 29335, 14668, 7334, 3667, 1833,
		917, 458, 229, 115, 57, 29, 14, 7
	};

	logic [47:0]     sample_q [$];
	heading_result_t heading_q [$];
	int errors = 0;
	int burst_left = 1;
	int gap_left = 0;
	int rdy_left = 0;
	int stall_cycles = 0;

	function automatic longint calibrate_axis(input longint mx, my, mz,
			input logic signed [COEF_W-1:0] wx, wy, wz, input logic signed [OFF_W-1:0] off);
		longint acc;
		acc = longint'(wx) * mx + longint'(wy) * my + longint'(wz) * mz - longint'(off) * 1024;
		acc = acc / 16384;
		if (acc > 65535)
			acc = 65535;
		if (acc < -65536)
			acc = -65536;
		return acc;
	endfunction

	function automatic int cordic_angle(input longint xin, yin);
		longint x, y, z, dx, dy, r, lim;
		x = xin * 256;
		y = yin * 256;
		z = 0;
		if (x < 0) begin
			z = (y >= 0) ? (longint'(180) << ZFRAC) : -(longint'(180) << ZFRAC);
			x = -x;
			y = -y;
		end
		for (int i = 0; i < STEPS && i < 24; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (y > 0) begin
				x += dx;
				y -= dy;
				z += atan_tab[i];
			end else begin
				x -= dx;
				y += dy;
				z -= atan_tab[i];
			end
		end
		r = (z + (longint'(1) << (ZFRAC - FRAC - 1))) >>> (ZFRAC - FRAC);
		lim = longint'(180) << FRAC;
		if (r > lim)
			r = lim;
		if (r < -lim)
			r = -lim;
		return int'(r);
	endfunction

	function automatic heading_result_t predict_heading(input logic [47:0] s);
		heading_result_t r;
		longint mx, my, mz, cx, cy;
		int head;
		mx = longint'($signed(s[15:0]));
		my = longint'($signed(s[31:16]));
		mz = longint'($signed(s[47:32]));
		cx = calibrate_axis(mx, my, mz, coef_reg[REG_COEF_XX], coef_reg[REG_COEF_XY],
			coef_reg[REG_COEF_XZ], off_x_reg);
		cy = calibrate_axis(mx, my, mz, coef_reg[REG_COEF_YX], coef_reg[REG_COEF_YY],
			coef_reg[REG_COEF_YZ], off_y_reg);
		if (cx == 0) begin
			head = hist_last;
			r.held = 1'b1;
		end else begin
			head = (cordic_angle(cx, -cy) + hist_last + hist_older) / 3;
			hist_oldest = hist_older;
			hist_older = hist_last;
			hist_last = head;
			r.held = 1'b0;
		end
		r.heading = head[HEAD_W-1:0];
		r.cal_x = cx[CAL_W-1:0];
		r.cal_y = cy[CAL_W-1:0];
		return r;
	endfunction

	function automatic int srand(input int r);
		return int'($urandom_range(0, 2 * r)) - r;
	endfunction

	function automatic logic [47:0] pack_sample(input int x, y, z);
		return {z[15:0], y[15:0], x[15:0]};
	endfunction

	function automatic logic [47:0] rand_sample();
		int v [3];
		case ($urandom_range(0, 5))
			0, 1: return 48'({$urandom, $urandom});
			2: return pack_sample(srand(2000), srand(2000), srand(2000));
			3: return pack_sample(srand(20000), srand(20000), srand(20000));
			4: return pack_sample($urandom_range(0, 1) ? 0 : srand(50),
				$urandom_range(0, 1) ? 0 : srand(1), srand(50));
			default: begin
				foreach (v[k]) begin
					case ($urandom_range(0, 4))
						0: v[k] = -32768;
						1: v[k] = -1;
						2: v[k] = 0;
						3: v[k] = 1;
						default: v[k] = 32767;
					endcase
				end
				return pack_sample(v[0], v[1], v[2]);
			end
		endcase
	endfunction

	task automatic write_reg(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= val;
		if (idx <= REG_COEF_YZ)
			coef_reg[idx] = val[COEF_W-1:0];
		else if (idx == REG_OFFSET_X)
			off_x_reg = val;
		else
			off_y_reg = val;
	endtask

	task automatic set_cal(input int xx, xy, xz, yx, yy, yz, ox, oy);
		write_reg(REG_COEF_XX, 20'(xx));
		write_reg(REG_COEF_XY, 20'(xy));
		write_reg(REG_COEF_XZ, 20'(xz));
		write_reg(REG_COEF_YX, 20'(yx));
		write_reg(REG_COEF_YY, 20'(yy));
		write_reg(REG_COEF_YZ, 20'(yz));
		write_reg(REG_OFFSET_X, 20'(ox));
		write_reg(REG_OFFSET_Y, 20'(oy));
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic push_random(input int n);
		repeat (n) sample_q.push_back(rand_sample());
	endtask

	task automatic push_corners();
		for (int k = 0; k < 8; k++)
			sample_q.push_back(pack_sample(k[0] ? 32767 : -32768, k[1] ? 32767 : -32768,
				k[2] ? 32767 : -32768));
		sample_q.push_back('0);
	endtask

	// hold until every item is through, plus margin for the pipeline
	task automatic wait_idle();
		do
			@(posedge clk);
		while (sample_q.size() != 0 || s_axis_tvalid || heading_q.size() != 0);
		repeat (32) @(posedge clk);
	endtask

	initial begin
		coef_reg[REG_COEF_XX] = COEF_XX_RST;
		coef_reg[REG_COEF_XY] = COEF_XY_RST;
		coef_reg[REG_COEF_XZ] = COEF_XZ_RST;
		coef_reg[REG_COEF_YX] = COEF_YX_RST;
		coef_reg[REG_COEF_YY] = COEF_YY_RST;
		coef_reg[REG_COEF_YZ] = COEF_YZ_RST;
		off_x_reg = OFFSET_X_RST;
		off_y_reg = OFFSET_Y_RST;
		hist_last = 0;
		hist_older = 0;
		hist_oldest = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// default calibration: x follows raw y, y follows raw x
		sample_q.push_back(pack_sample(0, 0, 0));
		sample_q.push_back(pack_sample(32767, 32767, 32767));
		sample_q.push_back(pack_sample(-32768, -32768, -32768));
		sample_q.push_back(pack_sample(32767, -32768, 0));
		sample_q.push_back(pack_sample(-32768, 32767, 0));
		sample_q.push_back(pack_sample(0, 0, 32767));
		sample_q.push_back(pack_sample(0, 0, -32768));
		sample_q.push_back(pack_sample(1, 1, 1));
		sample_q.push_back(pack_sample(-1, -1, -1));
		sample_q.push_back(pack_sample(0, 1000, 0));
		sample_q.push_back(pack_sample(0, -1000, 0));
		sample_q.push_back(pack_sample(48, -1000, 0));
		sample_q.push_back(pack_sample(48, -1000, 0));
		sample_q.push_back(pack_sample(2000, -1000, 0));
		sample_q.push_back(pack_sample(0, 1, 0));
		sample_q.push_back(pack_sample(0, 5000, 0));
		sample_q.push_back(pack_sample(10000, 5000, 0));
		sample_q.push_back(pack_sample(-10000, 5000, 0));
		sample_q.push_back(pack_sample(10000, -5000, 0));
		sample_q.push_back(pack_sample(-10000, -5000, 0));
		sample_q.push_back(pack_sample(-10000, -5000, 0));
		sample_q.push_back(pack_sample(-10000, -5000, 0));
		push_random(150);
		wait_idle();
		push_random(150);
		wait_idle();

		set_cal(32767, 32767, 32767, 32767, 32767, 32767, 524287, 524287);
		push_corners();
		push_random(80);
		wait_idle();

		set_cal(-32768, -32768, -32768, -32768, -32768, -32768, -524288, -524288);
		push_corners();
		push_random(80);
		wait_idle();

		// cal_x and cal_y both truncate to zero: every item held
		set_cal(0, 0, 0, 0, 0, 0, 15, -15);
		push_random(20);
		wait_idle();

		set_cal(16384, 0, 0, 0, 16384, 0, 0, 0);
		push_corners();
		push_random(300);
		wait_idle();

		for (int p = 0; p < 6; p++) begin
			if (p % 2 == 0)
				set_cal(16384 + srand(3000), srand(2000), srand(1000), srand(2000),
					16384 + srand(3000), srand(1000), srand(20000), srand(20000));
			else
				set_cal($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
					$urandom, $urandom);
			push_random(155);
			wait_idle();
		end

		repeat (40) @(posedge clk);
		if (errors == 0 && heading_q.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	// sender: bursts with random gaps
	always @(posedge clk) begin
		logic        nxt_valid;
		logic [47:0] nxt_data;
		if (arst_n) begin
			nxt_valid = s_axis_tvalid;
			nxt_data = s_axis_tdata;
			if (s_axis_tvalid && s_axis_tready) begin
				heading_q.push_back(predict_heading(s_axis_tdata));
				nxt_valid = 1'b0;
			end
			if (!nxt_valid) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (sample_q.size() > 0) begin
					nxt_data = sample_q.pop_front();
					nxt_valid = 1'b1;
					burst_left--;
					if (burst_left <= 0) begin
						burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
							: $urandom_range(1, 6);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
					end
				end
			end
			s_axis_tvalid <= nxt_valid;
			s_axis_tdata <= nxt_data;
		end
	end

	// receiver stall pattern
	always @(posedge clk) begin
		if (arst_n) begin
			if (rdy_left == 0) begin
				case ($urandom_range(0, 3))
					0: begin
						m_axis_tready <= 1'b1;
						rdy_left <= $urandom_range(20, 200);
					end
					1: begin
						m_axis_tready <= 1'b0;
						rdy_left <= $urandom_range(1, 40);
					end
					2: begin
						m_axis_tready <= 1'b1;
						rdy_left <= $urandom_range(1, 8);
					end
					default: begin
						m_axis_tready <= 1'b0;
						rdy_left <= $urandom_range(1, 4);
					end
				endcase
			end else begin
				rdy_left <= rdy_left - 1;
			end
		end
	end

	task automatic check_field(input string name, input int exp_v, input int got_v);
		if (exp_v != got_v) begin
			$error("%s: expected %0d, got %0d", name, exp_v, got_v);
			errors++;
		end
	endtask

	always @(posedge clk) begin
		heading_result_t e;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (heading_q.size() == 0) begin
				$error("unexpected item: heading_deg %0d", $signed(m_axis_tdata[15:0]));
				errors++;
			end else begin
				e = heading_q.pop_front();
				check_field("heading_deg", int'(e.heading), int'($signed(m_axis_tdata[15:0])));
				check_field("cal_x", int'(e.cal_x), int'($signed(m_axis_tdata[32:16])));
				check_field("cal_y", int'(e.cal_y), int'($signed(m_axis_tdata[49:33])));
				check_field("held", int'(e.held), int'(m_axis_tuser));
			end
		end
	end

	// watchdog: work pending but nothing moving
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
					|| (heading_q.size() == 0 && !s_axis_tvalid)) begin
				stall_cycles <= 0;
			end else if (stall_cycles >= STALL_LIMIT) begin
				$display("RESULT: ERROR");
				$finish;
			end else begin
				stall_cycles <= stall_cycles + 1;
			end
		end
	end

endmodule

// File: filelist.f
rtl/chf_pkg.sv
rtl/compass_heading_filter_top.sv
test/testbench.sv
